/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property templates for the checker module of the LED ring block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LRPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrps: same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define LRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrps: next-cycle assertion failed");

`endif

/* design/lrps_pkg.sv */
// ----------------------------------------------------------------------------
// lrps_pkg
// Types, widths and codes shared by the LED ring pattern sequencer files.
// ----------------------------------------------------------------------------
package lrps_pkg;

	// Ring size and derived widths
	localparam int NUM_LEDS  = 8;
	localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int LEDIDX_W  = 3;

	// Palette and colour widths
	localparam int PAL_DEPTH = 8;
	localparam int PAL_IDX_W = 3;
	localparam int CH_W      = 8;
	localparam int COLOR_W   = 3 * CH_W;

	// Timing counters
	localparam int TICK_W      = 13;
	localparam int HALF_W      = TICK_W - 1;
	localparam int MS_PER_TICK = 10;

	// Shared divider widths: dividend holds tick count times ten
	localparam int DIVD_W    = 17;
	localparam int DVS_W     = 16;
	localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

	// Configuration register widths
	localparam int MODE_W   = 3;
	localparam int PERIOD_W = 16;
	localparam int CCNT_W   = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_VAL_W = 16;

	// Input item command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_MODE = 2'd0,
		CFG_CYCLE_COLORS = 2'd1,
		CFG_PERIOD_MS    = 2'd2,
		CFG_COLOR_COUNT  = 2'd3
	} cfg_reg_t;

	// Pattern mode codes
	typedef enum logic [MODE_W-1:0] {
		MODE_ALL_ON       = 3'd0,
		MODE_BLINK        = 3'd1,
		MODE_WARNING      = 3'd2,
		MODE_CROSSED      = 3'd3,
		MODE_CIRCLE_LEFT  = 3'd4,
		MODE_CIRCLE_RIGHT = 3'd5
	} mode_t;

	// Channel words
	typedef struct packed {
		logic            command;
		logic            restart;
		logic [2:0]      entry_index;
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} in_word_t;

	typedef struct packed {
		logic [LEDIDX_W-1:0] led_index;
		logic [CH_W-1:0]     red_out;
		logic [CH_W-1:0]     green_out;
		logic [CH_W-1:0]     blue_out;
		logic                last;
	} out_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_VAL_W-1:0] value;
	} cfg_word_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
		logic [DVS_W-1:0]  remainder;
	} div_rsp_t;

endpackage

/* design/lrps_if.sv */
// ----------------------------------------------------------------------------
// lrps channel interfaces
// Valid/ready channels for input items, result words and register writes.
// ----------------------------------------------------------------------------
interface lrps_in_if;
	import lrps_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lrps_out_if;
	import lrps_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lrps_cfg_if;
	import lrps_pkg::*;

	logic      valid;
	logic      ready;
	cfg_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/led_ring_pattern_sequencer_core.sv */
// ----------------------------------------------------------------------------
// led_ring_pattern_sequencer_core
// Palette-driven pattern engine for a ring of LEDs, one colour word per change.
// ----------------------------------------------------------------------------
// A load word writes one palette entry and leaves the block in idle, so it
// is ready for the next item. A tick word updates the period counter in the
// S_STEPS state (period/10 by reciprocal multiply, period/NUM_LEDS by shift),
// then runs up to two divisions (tick*10 over period/NUM_LEDS, tick modulo
// the half period) through one shared bit-serial divider, skipping each
// division whose divisor, the circle divisor or the half period, is zero,
// then walks the ring one LED per cycle unless the result side holds off.
// No walk is made when no refresh is due. Only LEDs whose shown colour
// changes produce a result word, in ascending LED order, with last set on
// the final word of the tick. Input is refused from tick acceptance until
// its last word has been handed to the output register; register writes
// are always taken and belong in idle time.
module led_ring_pattern_sequencer_core (
	input  logic       clk,
	input  logic       arst_n,
	lrps_in_if.sink    item,
	lrps_out_if.source result,
	lrps_cfg_if.sink   cfg
);
	import lrps_pkg::*;

	localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);
	localparam logic [LED_W-1:0] LED_HALF = LED_W'(NUM_LEDS / 2);

	// Divide by ten: multiply by ceil(2^19/10), exact for 16-bit periods
	localparam int          DIV10_W     = 17;
	localparam int          DIV10_SHIFT = 19;
	localparam int          RECIP_W     = PERIOD_W + DIV10_W;
	localparam logic [16:0] DIV10_MUL   = 17'd52429;

	typedef enum logic [3:0] {
		S_IDLE,
		S_STEPS,
		S_CDIV,
		S_STEP,
		S_HALF,
		S_REM,
		S_DECIDE,
		S_WALK,
		S_FLUSH
	} state_t;

	// Configuration registers
	logic [MODE_W-1:0]   mode_q;
	logic                cycle_q;
	logic [PERIOD_W-1:0] period_q;
	logic [CCNT_W-1:0]   ccnt_q;

	// Stores
	logic [COLOR_W-1:0] palette_q [PAL_DEPTH];
	logic [COLOR_W-1:0] shown_q [NUM_LEDS];

	// Sequencer state
	state_t             state_q;
	logic               restart_q;
	logic [TICK_W-1:0]  tick_q;
	logic [PAL_IDX_W-1:0] color_idx_q;
	logic [HALF_W-1:0]  half_q;
	logic               step_ok_q;
	logic [DIVD_W-1:0]  step_q;
	logic               rem_zero_q;
	logic [LED_W-1:0]   led_q;
	logic               pend_valid_q;
	out_word_t          pend_q;
	logic               out_valid_q;
	out_word_t          out_q;
	div_req_t           req_q;
	div_rsp_t           div_rsp;

	logic               item_acc;
	logic               out_free;
	logic [RECIP_W-1:0] recip_prod;
	logic [TICK_W-1:0]  steps_w;
	logic [DVS_W-1:0]   cdiv_w;
	logic [PAL_IDX_W-1:0] count_m1;
	logic [PAL_IDX_W-1:0] ci_base;
	logic [TICK_W-1:0]  tick_next;
	logic [PAL_IDX_W-1:0] ci_next;
	logic               first_half;
	logic               refresh;
	logic [LED_W-1:0]   led_nxt;
	logic [LED_W-1:0]   led_mir;
	logic [LED_W-1:0]   led_mirn;
	logic               lit;
	logic [PAL_IDX_W-1:0] pal_addr;
	logic [COLOR_W-1:0] target;
	logic               changed;
	logic               walk_go;
	logic               div_go;
	logic               out_load;
	out_word_t          new_word;

	assign item_acc     = item.valid && item.ready;
	assign item.ready   = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;
	assign out_free     = !out_valid_q || result.ready;

	// Shared divider
	lrps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (div_rsp)
	);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_ALL_ON;
			cycle_q  <= 1'b0;
			period_q <= '0;
			ccnt_q   <= CCNT_W'(PAL_DEPTH);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.index)
				CFG_PATTERN_MODE: mode_q   <= cfg.data.value[MODE_W-1:0];
				CFG_CYCLE_COLORS: cycle_q  <= cfg.data.value[0];
				CFG_PERIOD_MS:    period_q <= cfg.data.value[PERIOD_W-1:0];
				CFG_COLOR_COUNT:  ccnt_q   <= cfg.data.value[CCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Palette load
	always_ff @(posedge clk) begin
		if (item_acc && item.data.command == CMD_LOAD) begin
			palette_q[item.data.entry_index] <=
				{item.data.red_in, item.data.green_in, item.data.blue_in};
		end
	end

	// Period counter and colour index advance
	always_comb begin
		recip_prod = RECIP_W'(period_q) * RECIP_W'(DIV10_MUL);
		steps_w    = recip_prod[DIV10_SHIFT +: TICK_W];
		cdiv_w     = DVS_W'(period_q / NUM_LEDS);
		if (ccnt_q == '0) begin
			count_m1 = '0;
		end else if (ccnt_q > CCNT_W'(PAL_DEPTH)) begin
			count_m1 = PAL_IDX_W'(PAL_DEPTH - 1);
		end else begin
			count_m1 = PAL_IDX_W'(ccnt_q - 1'b1);
		end
		ci_base = restart_q ? '0 : color_idx_q;
		if (tick_q >= steps_w) begin
			tick_next = '0;
			ci_next   = (ci_base >= count_m1) ? '0 : ci_base + 1'b1;
		end else begin
			tick_next = tick_q + 1'b1;
			ci_next   = ci_base;
		end
	end

	// Refresh decision
	always_comb begin
		first_half = tick_q < TICK_W'(half_q);
		refresh = restart_q || (cycle_q && tick_q == '0) ||
			((mode_q == MODE_BLINK || mode_q == MODE_WARNING || mode_q == MODE_CROSSED) &&
			 half_q != '0 && rem_zero_q) ||
			mode_q == MODE_CIRCLE_LEFT || mode_q == MODE_CIRCLE_RIGHT;
	end

	// Lit test and target colour for the current LED
	always_comb begin
		led_nxt  = (led_q == LED_LAST) ? '0 : led_q + 1'b1;
		led_mir  = LED_LAST - led_q;
		led_mirn = LED_LAST - led_nxt;
		case (mode_q)
			MODE_ALL_ON:       lit = 1'b1;
			MODE_BLINK:        lit = first_half;
			MODE_WARNING:      lit = first_half ? (led_q >= LED_HALF) : (led_q < LED_HALF);
			MODE_CROSSED:      lit = first_half ? !led_q[0] : led_q[0];
			MODE_CIRCLE_LEFT:  lit = step_ok_q && (DIVD_W'(led_mir) == step_q ||
			                                      DIVD_W'(led_mirn) == step_q);
			MODE_CIRCLE_RIGHT: lit = step_ok_q && (DIVD_W'(led_q) == step_q ||
			                                      DIVD_W'(led_nxt) == step_q);
			default:           lit = 1'b0;
		endcase
		pal_addr = cycle_q ? color_idx_q : PAL_IDX_W'(led_q);
		target   = lit ? palette_q[pal_addr] : '0;
		changed  = shown_q[led_q] != target;
		walk_go  = !changed || !pend_valid_q || out_free;

		new_word.led_index = LEDIDX_W'(led_q);
		new_word.red_out   = target[3*CH_W-1:2*CH_W];
		new_word.green_out = target[2*CH_W-1:CH_W];
		new_word.blue_out  = target[CH_W-1:0];
		new_word.last      = 1'b0;
	end

	// Divider request and output register load
	always_comb begin
		div_go   = (state_q == S_CDIV && cdiv_w != '0) ||
			(state_q == S_HALF && half_q != '0);
		out_load = (state_q == S_WALK && walk_go && changed && pend_valid_q) ||
			(state_q == S_FLUSH && pend_valid_q && out_free);
	end

	// Sequencer: division passes, ring walk, output hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			restart_q    <= 1'b0;
			tick_q       <= '0;
			color_idx_q  <= '0;
			half_q       <= '0;
			step_ok_q    <= 1'b0;
			step_q       <= '0;
			rem_zero_q   <= 1'b0;
			led_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			req_q        <= '0;
			for (int i = 0; i < NUM_LEDS; i++) begin
				shown_q[i] <= '0;
			end
		end else begin
			req_q.start <= div_go;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_acc && item.data.command == CMD_TICK) begin
						restart_q <= item.data.restart;
						state_q   <= S_STEPS;
					end
				end
				S_STEPS: begin
					tick_q      <= tick_next;
					color_idx_q <= ci_next;
					half_q      <= steps_w[TICK_W-1:1];
					state_q     <= S_CDIV;
				end
				S_CDIV: begin
					if (cdiv_w != '0) begin
						step_ok_q      <= 1'b1;
						req_q.dividend <= DIVD_W'(tick_q) * DIVD_W'(MS_PER_TICK);
						req_q.divisor  <= cdiv_w;
						state_q        <= S_STEP;
					end else begin
						step_ok_q <= 1'b0;
						state_q   <= S_HALF;
					end
				end
				S_STEP: begin
					if (div_rsp.done) begin
						step_q  <= div_rsp.quotient;
						state_q <= S_HALF;
					end
				end
				S_HALF: begin
					if (half_q != '0) begin
						req_q.dividend <= DIVD_W'(tick_q);
						req_q.divisor  <= DVS_W'(half_q);
						state_q        <= S_REM;
					end else begin
						rem_zero_q <= 1'b0;
						state_q    <= S_DECIDE;
					end
				end
				S_REM: begin
					if (div_rsp.done) begin
						rem_zero_q <= (div_rsp.remainder == '0);
						state_q    <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					led_q   <= '0;
					state_q <= refresh ? S_WALK : S_IDLE;
				end
				S_WALK: begin
					// Hold a found change until the next one shows it is not the last
					if (walk_go) begin
						if (changed) begin
							shown_q[led_q] <= target;
							pend_q         <= new_word;
							pend_valid_q   <= 1'b1;
							if (pend_valid_q) begin
								out_q <= pend_q;
							end
						end
						if (led_q == LED_LAST) begin
							state_q <= S_FLUSH;
						end else begin
							led_q <= led_q + 1'b1;
						end
					end
				end
				S_FLUSH: begin
					// Drop the held change out as the final word of the tick
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q <= '{led_index: pend_q.led_index,
							red_out: pend_q.red_out,
							green_out: pend_q.green_out,
							blue_out: pend_q.blue_out,
							last: 1'b1};
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* design/lrps_div.sv */
// ----------------------------------------------------------------------------
// lrps_div
// Shared restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module lrps_div (
	input  logic               clk,
	input  logic               arst_n,
	input  lrps_pkg::div_req_t req,
	output lrps_pkg::div_rsp_t rsp
);
	import lrps_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           fits;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[DIVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Iterate over the dividend bits, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

/* design/lrps_checker.sv */
// ----------------------------------------------------------------------------
// lrps_checker
// Port-level checks of the LED ring sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrps_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                item_command,
	input logic                result_valid,
	input logic                result_ready,
	input lrps_pkg::out_word_t result_data
);
	import lrps_pkg::*;

	// A stalled result word holds
	`LRPS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_data))

	// A tick keeps the input closed on the next cycle
	`LRPS_ASSERT_NEXT(a_tick_busy, clk, arst_n, item_valid && item_ready && item_command == CMD_TICK, !item_ready)

	// A palette load leaves the block ready
	`LRPS_ASSERT_NEXT(a_load_ready, clk, arst_n, item_valid && item_ready && item_command == CMD_LOAD, item_ready)

	// More words of the same tick follow: the input stays closed
	`LRPS_ASSERT_SAME(a_chain_busy, clk, arst_n, result_valid && !result_data.last, !item_ready)

endmodule

bind led_ring_pattern_sequencer_core lrps_checker u_lrps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_command (item.data.command),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);
